### rtl/gha_pkg.sv
package gha_pkg;

   localparam int GEN_W    = 32;
   localparam int ID_W     = 8;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;

   localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_STALE = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_POP,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic [GEN_W-1:0] gen;
      logic             alive;
   } slot_type;

endpackage

### rtl/generational_handle_allocator_top.sv
// Generational handle allocator. Hands out handles (slot id plus 32-bit
// generation) from a pool of ENTRIES slots kept on a LIFO free stack, and
// checks handles on release and query. One transaction is in work at a time.
// A release, a query, an unused kind or an allocate on an empty pool does its
// slot-table read at the accepting edge; the lookup state then registers its
// result. An allocate from a non-empty pool adds the pop state between them
// (free-stack read, then the slot-table read of the popped id). The lookup
// state holds while a finished result waits in the output register on
// rsp_tready. A new request is taken while a finished result still sits in
// the output register. After reset a clearing pass over all ENTRIES entries
// initializes the free stack and the slot table; req_tready stays low during
// it. State lives in two single-port-write memories with registered reads:
// the free stack and the slot table (generation and alive bit per slot).
module generational_handle_allocator_top
   import gha_pkg::*;
#(
   parameter int ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request: tdata = handle_id[7:0], handle_generation[39:8]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,
   // request: tuser = kind[1:0]
   input  logic [1:0]  req_tuser,
   // response: tdata = slot_id[7:0], slot_generation[39:8], is_alive[40],
   //                   pad[47:41]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   // response: tuser = status[1:0]
   output logic [1:0]  rsp_tuser
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // storage
   slot_type         slot_mem  [ENTRIES];
   logic [IDX_W-1:0] stack_mem [ENTRIES];

   // control
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] free_count_ff, free_count_in;

   // request capture
   logic [KIND_W-1:0] kind_ff;
   logic [ID_W-1:0]   id_ff;
   logic [GEN_W-1:0]  gen_ff;
   logic              in_range_ff;

   // memory read data
   slot_type          slot_rd_ff;
   logic [IDX_W-1:0]  stack_rd_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [GEN_W-1:0]    rsp_gen_ff, rsp_gen_in;
   logic                rsp_alive_ff, rsp_alive_in;

   // strobes
   logic accept, finish, clr_last;
   logic slot_re, stack_re;
   logic slot_we, stack_we;
   logic [IDX_W-1:0] slot_raddr, slot_waddr, stack_raddr, stack_waddr;
   slot_type         slot_wdata;
   logic [IDX_W-1:0] stack_wdata;

   // datapath decisions in the lookup state
   logic             upd_alloc, upd_release;
   logic [IDX_W-1:0] cur_idx;
   logic [GEN_W-1:0] cur_gen;
   logic             cur_alive, hdl_valid;
   logic [CNT_W-1:0] cnt_m1;

   logic [ID_W-1:0]  req_id;
   logic [GEN_W-1:0] req_gen;

   assign req_id   = req_tdata[ID_W-1:0];
   assign req_gen  = req_tdata[ID_W+GEN_W-1:ID_W];
   assign accept   = req_tvalid && req_tready;
   assign clr_last = (clr_ff == IDX_W'(ENTRIES - 1));
   assign cnt_m1   = free_count_ff - 1'b1;

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == KIND_ALLOC && free_count_ff != '0) state_in = ST_POP;
               else state_in = ST_LOOKUP;
            end
         end
         ST_POP: begin
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (finish) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // ---------------- FSM outputs ----------------
   always_comb begin
      req_tready  = 1'b0;
      stack_re    = 1'b0;
      slot_re     = 1'b0;
      finish      = 1'b0;
      slot_raddr  = IDX_W'(32'(req_id));
      stack_raddr = cnt_m1[IDX_W-1:0];
      unique case (state_ff)
         ST_CLEAR: ;
         ST_IDLE: begin
            req_tready = 1'b1;
            stack_re   = req_tvalid;
            slot_re    = req_tvalid;
         end
         ST_POP: begin
            // popped id selects the slot entry
            slot_re    = 1'b1;
            slot_raddr = stack_rd_ff;
         end
         ST_LOOKUP: begin
            finish = !rsp_valid_ff || rsp_tready;
         end
         default: ;
      endcase
   end

   // ---------------- lookup / update ----------------
   always_comb begin
      cur_idx   = (kind_ff == KIND_ALLOC) ? stack_rd_ff : IDX_W'(32'(id_ff));
      cur_gen   = in_range_ff ? slot_rd_ff.gen : '0;
      cur_alive = in_range_ff && slot_rd_ff.alive;
      hdl_valid = in_range_ff && (slot_rd_ff.gen == gen_ff);

      upd_alloc   = 1'b0;
      upd_release = 1'b0;
      rsp_status_in = STATUS_STALE;
      rsp_id_in     = id_ff;
      rsp_gen_in    = '0;
      rsp_alive_in  = 1'b0;

      case (kind_ff)
         KIND_ALLOC: begin
            if (free_count_ff == '0) begin
               rsp_status_in = STATUS_EMPTY;
               rsp_id_in     = '0;
            end else begin
               upd_alloc     = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_id_in     = ID_W'(32'(stack_rd_ff));
               rsp_gen_in    = slot_rd_ff.gen;
               rsp_alive_in  = 1'b1;
            end
         end
         KIND_RELEASE: begin
            if (hdl_valid && cur_alive && free_count_ff < CNT_W'(ENTRIES)) begin
               upd_release   = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_gen_in    = cur_gen + 1'b1;
            end else begin
               rsp_gen_in   = cur_gen;
               rsp_alive_in = cur_alive;
            end
         end
         KIND_QUERY: begin
            rsp_gen_in = cur_gen;
            if (hdl_valid && cur_alive) begin
               rsp_status_in = STATUS_OK;
               rsp_alive_in  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // memory write side: clearing pass or committed update
   always_comb begin
      slot_we     = 1'b0;
      stack_we    = 1'b0;
      slot_waddr  = cur_idx;
      stack_waddr = free_count_ff[IDX_W-1:0];
      slot_wdata  = '{gen: slot_rd_ff.gen, alive: 1'b1};
      stack_wdata = cur_idx;
      clr_in      = clr_ff;
      if (state_ff == ST_CLEAR) begin
         // stack entry k holds ENTRIES-1-k so id 0 pops first
         slot_we     = 1'b1;
         stack_we    = 1'b1;
         slot_waddr  = clr_ff;
         stack_waddr = clr_ff;
         slot_wdata  = '0;
         stack_wdata = IDX_W'(ENTRIES - 1) - clr_ff;
         clr_in      = clr_ff + 1'b1;
      end else if (finish && upd_alloc) begin
         slot_we = 1'b1;
      end else if (finish && upd_release) begin
         slot_we    = 1'b1;
         stack_we   = 1'b1;
         slot_wdata = '{gen: rsp_gen_in, alive: 1'b0};
      end
   end

   always_comb begin
      free_count_in = free_count_ff;
      if (finish && upd_alloc) free_count_in = cnt_m1;
      else if (finish && upd_release) free_count_in = free_count_ff + 1'b1;
   end

   always_comb begin
      if (finish) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
      if (slot_re) slot_rd_ff <= slot_mem[slot_raddr];
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
      if (stack_re) stack_rd_ff <= stack_mem[stack_raddr];
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         free_count_ff <= CNT_W'(ENTRIES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= req_tuser;
         id_ff       <= req_id;
         gen_ff      <= req_gen;
         in_range_ff <= (32'(req_id) < ENTRIES);
      end
      if (finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_gen_ff    <= rsp_gen_in;
         rsp_alive_ff  <= rsp_alive_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_alive_ff, rsp_gen_ff, rsp_id_ff};

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      free_count_ff <= CNT_W'(ENTRIES))
      else $error("free count above pool size");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !req_tready)
      else $error("request taken during clearing pass");

   a_release_push: assert property (@(posedge clock) disable iff (reset)
      finish && upd_release |=> free_count_ff == $past(free_count_ff) + 1'b1)
      else $error("release did not push the free stack");

   a_alloc_pop: assert property (@(posedge clock) disable iff (reset)
      finish && upd_alloc |=> free_count_ff == $past(free_count_ff) - 1'b1)
      else $error("allocate did not pop the free stack");
`endif

endmodule
